### src/lpht_pkg.sv
// Shared types and constants of the linear-probe hash table.
package lpht_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int CNT_W = 9;
    localparam int HASH_W = 32;
    localparam int OP_W = 2;

    // Table size; a power of two, so the home slot is the low hash bits.
    localparam int SLOTS = 256;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [CNT_W-1:0] FILL_LIMIT_RESET = 9'd192;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        C_IDLE,
        C_CLEAR,
        C_LOAD,
        C_HASH,
        C_MOD,
        C_PROBE_RD,
        C_PROBE_CHK,
        C_SHIFT_RD,
        C_SHIFT_CHK,
        C_FREE,
        C_DONE
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic op_none;
        logic probe_end;
        logic remove_hit;
        logic shift_done;
        logic shift_stop;
        logic out_busy;
    } t_status;

endpackage

### src/lpht_in_if.sv
// Request channel: operation, key and value with a valid/ready handshake.
interface lpht_in_if;
    logic                           valid;
    logic                           ready;
    logic [lpht_pkg::OP_W-1:0]      operation;
    logic [lpht_pkg::KEY_W-1:0]     key;
    logic [lpht_pkg::VAL_W-1:0]     value;

    modport source (output valid, operation, key, value, input ready);
    modport sink (input valid, operation, key, value, output ready);
endinterface

### src/lpht_out_if.sv
// Result channel: found flag, value, refusal and entry count.
interface lpht_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [lpht_pkg::VAL_W-1:0]     result_value;
    logic                           refused;
    logic [lpht_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, found, result_value, refused, entry_count, input ready);
    modport sink (input valid, found, result_value, refused, entry_count, output ready);
endinterface

### src/lpht_datapath.sv
// Datapath: key canonicalizer, FNV-1a hasher, home-slot select, slot memory.
module lpht_datapath #(
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpht_pkg::t_cmd              i_cmd,
    output lpht_pkg::t_status           o_status,
    input  logic                        i_cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [lpht_pkg::OP_W-1:0]   i_operation,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  logic [lpht_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic [lpht_pkg::VAL_W-1:0]  o_result_value,
    output logic                        o_refused,
    output logic [lpht_pkg::CNT_W-1:0]  o_entry_count
);

    localparam int IW = lpht_pkg::SLOT_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(lpht_pkg::SLOTS - 1);

    typedef struct packed {
        logic                       used;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::VAL_W-1:0] value;
        logic [IW-1:0]              home;
    } t_slot;

    t_slot r_mem [lpht_pkg::SLOTS];
    t_slot r_rd;

    logic [lpht_pkg::OP_W-1:0]   r_op;
    logic [lpht_pkg::KEY_W-1:0]  r_key;
    logic [lpht_pkg::VAL_W-1:0]  r_val;
    logic [lpht_pkg::HASH_W-1:0] r_hash;
    logic [2:0]                  r_bidx;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_home;
    logic [IW-1:0]               r_n;
    logic [IW-1:0]               r_hole;
    logic [IW-1:0]               r_scan;
    logic [IW-1:0]               r_left;
    logic [lpht_pkg::CNT_W-1:0]  r_count;
    logic [lpht_pkg::CNT_W-1:0]  r_fill;
    logic                        r_found;
    logic [lpht_pkg::VAL_W-1:0]  r_result;
    logic                        r_refused;
    logic                        r_out_valid;
    logic                        r_o_found;
    logic [lpht_pkg::VAL_W-1:0]  r_o_result;
    logic                        r_o_refused;
    logic [lpht_pkg::CNT_W-1:0]  r_o_count;

    logic [lpht_pkg::KEY_W-1:0]  canon;
    logic                        alive;
    logic [7:0]                  cur_byte;
    logic                        hit;
    logic                        empty;
    logic                        probe_last;
    logic                        move;
    logic                        room;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    t_slot                       wr_data;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] a);
        next_slot = (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    // Clear bytes after the first zero byte and beyond KEY_BYTES.
    always_comb begin
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            alive = alive && (i < KEY_BYTES) && (i_key[i*8 +: 8] != 8'd0);
            canon[i*8 +: 8] = alive ? i_key[i*8 +: 8] : 8'd0;
        end
    end

    assign cur_byte = r_key[{r_bidx, 3'b000} +: 8];

    assign hit        = r_rd.used && (r_rd.key == r_key);
    assign empty      = !r_rd.used;
    assign probe_last = (r_n == LAST_SLOT);
    assign room       = (r_count < r_fill) && (32'(r_count) < 32'(lpht_pkg::SLOTS));

    always_comb begin
        if (r_scan > r_hole) begin
            move = (r_rd.home <= r_hole) || (r_rd.home > r_scan);
        end else begin
            move = (r_rd.home > r_scan) && (r_rd.home <= r_hole);
        end
    end

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        case (i_cmd)
            lpht_pkg::C_CLEAR: begin
                wr_en = 1'b1;
            end
            lpht_pkg::C_PROBE_RD: begin
                rd_en = 1'b1;
            end
            lpht_pkg::C_PROBE_CHK: begin
                wr_data = '{used: 1'b1, key: r_key, value: r_val, home: r_home};
                wr_en = (r_op == lpht_pkg::OP_INSERT) && (hit || (empty && room));
            end
            lpht_pkg::C_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_scan;
            end
            lpht_pkg::C_SHIFT_CHK: begin
                wr_en   = r_rd.used && move;
                wr_addr = r_hole;
                wr_data = r_rd;
            end
            lpht_pkg::C_FREE: begin
                wr_en   = 1'b1;
                wr_addr = r_hole;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            case (i_cmd)
                lpht_pkg::C_CLEAR: begin
                    r_idx <= next_slot(r_idx);
                end
                lpht_pkg::C_LOAD: begin
                    r_op      <= i_operation;
                    r_key     <= canon;
                    r_val     <= i_value;
                    r_hash    <= lpht_pkg::FNV_BASIS;
                    r_bidx    <= '0;
                    r_found   <= 1'b0;
                    r_result  <= '0;
                    r_refused <= 1'b0;
                end
                lpht_pkg::C_HASH: begin
                    if (cur_byte != 8'd0) begin
                        r_hash <= (r_hash ^ {24'd0, cur_byte}) * lpht_pkg::FNV_PRIME;
                    end
                    r_bidx <= r_bidx + 1'b1;
                end
                lpht_pkg::C_MOD: begin
                    r_idx  <= r_hash[IW-1:0];
                    r_home <= r_hash[IW-1:0];
                    r_n    <= '0;
                end
                lpht_pkg::C_PROBE_CHK: begin
                    if (hit) begin
                        r_found  <= 1'b1;
                        r_result <= r_rd.value;
                        r_hole   <= r_idx;
                        r_scan   <= next_slot(r_idx);
                        r_left   <= LAST_SLOT;
                    end else if (empty) begin
                        r_refused <= (r_op == lpht_pkg::OP_INSERT) && !room;
                    end else if (probe_last) begin
                        r_refused <= (r_op == lpht_pkg::OP_INSERT);
                    end else begin
                        r_idx <= next_slot(r_idx);
                        r_n   <= r_n + 1'b1;
                    end
                end
                lpht_pkg::C_SHIFT_CHK: begin
                    if (r_rd.used && move) begin
                        r_hole <= r_scan;
                    end
                    r_scan <= next_slot(r_scan);
                    r_left <= r_left - 1'b1;
                end
                default: begin
                end
            endcase
            if (i_cmd == lpht_pkg::C_DONE && !(r_out_valid && !i_out_ready)) begin
                r_o_found   <= r_found;
                r_o_result  <= r_result;
                r_o_refused <= r_refused;
                r_o_count   <= r_count;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fill      <= lpht_pkg::FILL_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill <= i_cfg_data;
            end
            if (i_cmd == lpht_pkg::C_PROBE_CHK) begin
                if (hit && r_op == lpht_pkg::OP_REMOVE && r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end else if (empty && r_op == lpht_pkg::OP_INSERT && room) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd == lpht_pkg::C_DONE && !(r_out_valid && !i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clear_last = (r_idx == LAST_SLOT);
        o_status.hash_last  = (r_bidx == 3'd7);
        o_status.op_none    = (r_op != lpht_pkg::OP_INSERT) && (r_op != lpht_pkg::OP_LOOKUP)
                              && (r_op != lpht_pkg::OP_REMOVE);
        o_status.probe_end  = hit || empty || probe_last;
        o_status.remove_hit = hit && (r_op == lpht_pkg::OP_REMOVE);
        o_status.shift_done = (r_left == '0);
        o_status.shift_stop = !r_rd.used;
        o_status.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_result_value = r_o_result;
    assign o_refused      = r_o_refused;
    assign o_entry_count  = r_o_count;

endmodule

### src/lpht_ctrl.sv
// Controller: sequences clearing, hashing, probing and backward-shift deletion.
module lpht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpht_pkg::t_status   i_status,
    output lpht_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_PRD, S_PCHK, S_SRD, S_SCHK, S_FREE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = lpht_pkg::C_IDLE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = lpht_pkg::C_CLEAR;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd   = lpht_pkg::C_LOAD;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd = lpht_pkg::C_HASH;
                if (i_status.hash_last) n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd   = lpht_pkg::C_MOD;
                n_state = i_status.op_none ? S_DONE : S_PRD;
            end
            S_PRD: begin
                o_cmd   = lpht_pkg::C_PROBE_RD;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_cmd = lpht_pkg::C_PROBE_CHK;
                if (!i_status.probe_end) n_state = S_PRD;
                else if (i_status.remove_hit) n_state = S_SRD;
                else n_state = S_DONE;
            end
            S_SRD: begin
                if (i_status.shift_done) begin
                    n_state = S_FREE;
                end else begin
                    o_cmd   = lpht_pkg::C_SHIFT_RD;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_status.shift_stop) begin
                    n_state = S_FREE;
                end else begin
                    o_cmd   = lpht_pkg::C_SHIFT_CHK;
                    n_state = S_SRD;
                end
            end
            S_FREE: begin
                o_cmd   = lpht_pkg::C_FREE;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd = lpht_pkg::C_DONE;
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

endmodule

### src/linear_probe_hash_table.sv
// Top level of the linear-probe hash table with FNV-1a hashing.
//
// Usage:
//   i_in carries one request item: operation (insert/update, lookup, remove),
//   key of up to eight bytes (zero terminated) and value. o_out returns one
//   result item per request: found, result_value, refused, entry_count.
//   i_cfg_we/i_cfg_data write fill_limit; write it only while idle.
// Sequence:
//   One item at a time. An item takes a load step, a hash step for every key
//   byte position (one key byte through the FNV multiplier per cycle), a step
//   to take the home slot from the low hash bits, then a registered memory
//   read and a compare/write for each probed slot. A removal adds a read and
//   a check for each slot of the shift scan, the empty slot that ends it
//   included, plus a step to free the last hole. A final step moves the
//   result into the output register, and ready returns the cycle after.
// Reset:
//   Reset clears the entry count, output valid and sets fill_limit to 192,
//   then a clearing pass over all SLOTS (256) slots marks every slot unused;
//   input ready stays low during that pass.
// Backpressure:
//   The result waits in the output register; the block holds the finished
//   item and takes no new one until the result register is free.
module linear_probe_hash_table #(
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]  i_cfg_data,
    lpht_in_if.sink                     i_in,
    lpht_out_if.source                  o_out
);

    lpht_pkg::t_cmd    cmd;
    lpht_pkg::t_status status;

    // Sequencer: decide the work of each cycle.
    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: hold the item, hash it, walk the slot memory.
    lpht_datapath #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_in.operation),
        .i_key          (i_in.key),
        .i_value        (i_in.value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_found        (o_out.found),
        .o_result_value (o_out.result_value),
        .o_refused      (o_out.refused),
        .o_entry_count  (o_out.entry_count)
    );

endmodule

### src/lpht_checker.sv
// Port-level checks of the hash table and their binding to the top level.
module lpht_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_found,
    input logic [lpht_pkg::VAL_W-1:0]   i_result_value,
    input logic                         i_refused,
    input logic [lpht_pkg::CNT_W-1:0]   i_entry_count
);

    // One item in flight: an accepted item drops ready next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after accept");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_found)
            && $stable(i_result_value) && $stable(i_refused) && $stable(i_entry_count)))
        else $error("stalled result changed");

    a_refused_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_refused) |-> !i_found)
        else $error("refused and found together");

    a_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_result_value == '0))
        else $error("value on a miss");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_found        (o_out.found),
    .i_result_value (o_out.result_value),
    .i_refused      (o_out.refused),
    .i_entry_count  (o_out.entry_count)
);

### bench/lpht_bench_if.sv
`timescale 1ns / 1ps
// Bench-side constants shared by the testbench files.
package lpht_bench_pkg;
    localparam int BENCH_SLOTS = lpht_pkg::SLOTS;
endpackage

### bench/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Self-checking bench for the linear-probe hash table: random and directed
// insert/lookup/remove traffic checked against a behavioral table model.
module tb_linear_probe_hash_table;

    localparam int SLOTS = lpht_bench_pkg::BENCH_SLOTS;

    typedef struct {
        logic [lpht_pkg::OP_W-1:0]  operation;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::VAL_W-1:0] value;
    } t_request;

    typedef struct {
        logic                       found;
        logic [lpht_pkg::VAL_W-1:0] result_value;
        logic                       refused;
        logic [lpht_pkg::CNT_W-1:0] entry_count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lpht_pkg::CNT_W-1:0] i_cfg_data = '0;

    lpht_in_if  req_ch ();
    lpht_out_if rsp_ch ();

    linear_probe_hash_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow table state
    logic                        tbl_used [SLOTS];
    logic [lpht_pkg::KEY_W-1:0]  tbl_key  [SLOTS];
    logic [lpht_pkg::VAL_W-1:0]  tbl_val  [SLOTS];
    logic [lpht_pkg::HASH_W-1:0] tbl_hash [SLOTS];
    int unsigned      tbl_count;
    int unsigned      fill_cap;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       errors = 0;
    int       answers_seen = 0;
    int       hits_seen = 0;
    int       refusals_seen = 0;
    bit       quiet_mode = 1'b0;  // no idling in the last part of the run
    bit       hold_sender = 1'b0; // send only once every result is back

    // Cut the key at its first zero byte and hash the kept bytes with FNV-1a.
    function automatic logic [lpht_pkg::KEY_W-1:0] trim_key(
            input logic [lpht_pkg::KEY_W-1:0] raw,
            output logic [lpht_pkg::HASH_W-1:0] h);
        logic [lpht_pkg::KEY_W-1:0] kept;
        logic [7:0] b;
        bit stop;
        kept = '0;
        h = lpht_pkg::FNV_BASIS;
        stop = 0;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'h00) stop = 1;
            if (!stop) begin
                kept[8*i +: 8] = b;
                h = (h ^ {24'h0, b}) * lpht_pkg::FNV_PRIME;
            end
        end
        return kept;
    endfunction

    function automatic int unsigned step_slot(input int unsigned i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // Pull later chain members back into the hole left by a removal.
    task automatic close_gap(input int unsigned gap);
        int unsigned scan, home;
        bit shift;
        bit stop;
        scan = step_slot(gap);
        stop = 0;
        for (int s = 1; s < SLOTS; s++) begin
            if (!stop) begin
                if (!tbl_used[scan]) begin
                    stop = 1;
                end else begin
                    home = tbl_hash[scan] % SLOTS;
                    if (scan > gap) shift = (home <= gap) || (home > scan);
                    else            shift = (home > scan) && (home <= gap);
                    if (shift) begin
                        tbl_key[gap]  = tbl_key[scan];
                        tbl_val[gap]  = tbl_val[scan];
                        tbl_hash[gap] = tbl_hash[scan];
                        gap = scan;
                    end
                    scan = step_slot(scan);
                end
            end
        end
        tbl_used[gap] = 1'b0;
    endtask

    // Apply one request to the shadow table and return the answer it should get.
    task automatic apply_request(input t_request rq, output t_answer ans);
        logic [lpht_pkg::KEY_W-1:0] k;
        logic [lpht_pkg::HASH_W-1:0] h;
        int unsigned idx, pos;
        int hit;  // 1 found, 0 empty slot, -1 neither
        k = trim_key(rq.key, h);
        ans = '{1'b0, '0, 1'b0, '0};
        hit = -1;
        pos = 0;
        idx = h % SLOTS;
        if (rq.operation != lpht_pkg::OP_UNUSED) begin
            for (int n = 0; n < SLOTS; n++) begin
                if (hit == -1) begin
                    if (!tbl_used[idx]) begin
                        hit = 0; pos = idx;
                    end else if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
                        hit = 1; pos = idx;
                    end
                    idx = step_slot(idx);
                end
            end
            if (rq.operation == lpht_pkg::OP_INSERT) begin
                if (hit == 1) begin
                    ans.found = 1'b1;
                    ans.result_value = tbl_val[pos];
                    tbl_val[pos] = rq.value;
                end else if (hit == 0 && tbl_count < fill_cap && tbl_count < SLOTS) begin
                    tbl_used[pos] = 1'b1;
                    tbl_key[pos] = k;
                    tbl_val[pos] = rq.value;
                    tbl_hash[pos] = h;
                    tbl_count++;
                end else begin
                    ans.refused = 1'b1;
                end
            end else if (hit == 1) begin
                ans.found = 1'b1;
                ans.result_value = tbl_val[pos];
                if (rq.operation == lpht_pkg::OP_REMOVE) begin
                    tbl_count--;
                    close_gap(pos);
                end
            end
        end
        ans.entry_count = tbl_count[lpht_pkg::CNT_W-1:0];
    endtask

    // Driver: present queued items, with random idle bursts.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold the item until accepted
        end else begin
            t_answer a;
            if (req_ch.valid && req_ch.ready) begin
                apply_request('{req_ch.operation, req_ch.key, req_ch.value}, a);
                expected_answers.push_back(a);
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 18) - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(hold_sender && expected_answers.size() > 0)) begin
                t_request r;
                r = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.operation <= r.operation;
                req_ch.key <= r.key;
                req_ch.value <= r.value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest expectation.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_answer e;
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %b %h %b %0d",
                             $time, rsp_ch.found, rsp_ch.result_value, rsp_ch.refused,
                             rsp_ch.entry_count);
                    errors++;
                end else begin
                    e = expected_answers.pop_front();
                    if (e.found) hits_seen++;
                    if (e.refused) refusals_seen++;
                    if (rsp_ch.found !== e.found) begin
                        $display("%0t: found: expected %b, actual %b", $time, e.found,
                                 rsp_ch.found);
                        errors++;
                    end
                    if (rsp_ch.result_value !== e.result_value) begin
                        $display("%0t: result_value: expected %h, actual %h", $time,
                                 e.result_value, rsp_ch.result_value);
                        errors++;
                    end
                    if (rsp_ch.refused !== e.refused) begin
                        $display("%0t: refused: expected %b, actual %b", $time, e.refused,
                                 rsp_ch.refused);
                        errors++;
                    end
                    if (rsp_ch.entry_count !== e.entry_count) begin
                        $display("%0t: entry_count: expected %0d, actual %0d", $time,
                                 e.entry_count, rsp_ch.entry_count);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Keys come from a small pool so that hits, updates and removals are common.
    logic [lpht_pkg::KEY_W-1:0] key_pool[64];

    function automatic logic [lpht_pkg::KEY_W-1:0] rand_key();
        logic [lpht_pkg::KEY_W-1:0] k;
        int len;
        k = {$urandom, $urandom};
        len = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) begin
            if (i == len) k[8*i +: 8] = 8'h00;
        end
        return k;
    endfunction

    task automatic queue_req(input logic [lpht_pkg::OP_W-1:0] op,
                             input logic [lpht_pkg::KEY_W-1:0] k,
                             input logic [lpht_pkg::VAL_W-1:0] v);
        pending_reqs.push_back('{op, k, v});
    endtask

    // Drain every queued item and result, then let the block settle.
    task automatic drain_all();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_fill_cap(input int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[lpht_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fill_cap = v;
    endtask

    task automatic random_phase(input int n, input int pool_size);
        logic [lpht_pkg::OP_W-1:0] op;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = lpht_pkg::OP_INSERT;
            else if (pick < 70) op = lpht_pkg::OP_LOOKUP;
            else if (pick < 97) op = lpht_pkg::OP_REMOVE;
            else                op = lpht_pkg::OP_UNUSED;
            if ($urandom_range(0, 9) == 0)
                queue_req(op, {$urandom, $urandom}, $urandom);
            else
                queue_req(op, key_pool[$urandom_range(0, pool_size - 1)], $urandom);
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.key = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        fill_cap = lpht_pkg::FILL_LIMIT_RESET;
        tbl_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
            tbl_hash[i] = '0;
        end
        for (int i = 0; i < 64; i++) key_pool[i] = rand_key();
        key_pool[0] = '0;                      // empty key
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF; // full eight bytes
        key_pool[2] = 64'h00FF_FFFF_0000_0041; // bytes after the zero are dropped

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation, empty key, aliases, unknown op
        queue_req(lpht_pkg::OP_LOOKUP, '0, '0);
        queue_req(lpht_pkg::OP_INSERT, '0, 32'hFFFF_FFFF);
        queue_req(lpht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_req(lpht_pkg::OP_INSERT, 64'h1234_0000_0000_0041, 32'h5A5A_A5A5);
        queue_req(lpht_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, '0);
        queue_req(lpht_pkg::OP_INSERT, 64'h0000_0000_0000_0041, 32'h1111_2222);
        queue_req(lpht_pkg::OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(lpht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_req(lpht_pkg::OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_req(lpht_pkg::OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_req(lpht_pkg::OP_REMOVE, '0, '0);
        queue_req(lpht_pkg::OP_LOOKUP, 64'hFF00_0000_0000_0000, '0);
        drain_all();

        // Fill limit one: the table already holds one key, so new keys are refused and updates still succeed
        write_fill_cap(1);
        queue_req(lpht_pkg::OP_INSERT, 64'h42, 32'h1);
        queue_req(lpht_pkg::OP_INSERT, 64'h43, 32'h2);
        queue_req(lpht_pkg::OP_INSERT, 64'h0041, 32'h3);
        queue_req(lpht_pkg::OP_INSERT, 64'h42, 32'h4);
        drain_all();

        // Fill limit zero: every new key is refused
        write_fill_cap(0);
        queue_req(lpht_pkg::OP_INSERT, 64'h7777, 32'h9);
        random_phase(40, 32);
        drain_all();

        // Default-ish limit with broad traffic
        write_fill_cap(192);
        random_phase(260, 64);
        hold_sender = 1'b1;
        drain_all();
        hold_sender = 1'b0;

        // Fill limit above the slot count: run the table completely full
        write_fill_cap(511);
        for (int i = 0; i < 270; i++)
            queue_req(lpht_pkg::OP_INSERT, {$urandom, $urandom}, $urandom);
        random_phase(60, 64);
        drain_all();

        // Small limit during removes of the empty key; the churn that follows runs at limit 256
        write_fill_cap(8);
        for (int i = 0; i < 60; i++) queue_req(lpht_pkg::OP_REMOVE, '0, '0);
        drain_all();
        write_fill_cap(256);
        random_phase(150, 16);
        drain_all();

        quiet_mode = 1'b1;
        random_phase(100, 48);
        drain_all();

        $display("Ran %0d results: %0d hits, %0d refusals over fill limits 0 to 511.",
                 answers_seen, hits_seen, refusals_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: about 1000 items, each at worst a full probe, a full shift scan
    // and the longest stalls, allowed for several times over.
    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
src/lpht_pkg.sv
src/lpht_in_if.sv
src/lpht_out_if.sv
src/lpht_datapath.sv
src/lpht_ctrl.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
bench/lpht_bench_if.sv
bench/tb_linear_probe_hash_table.sv
